@@ src/dtp_pkg.sv @@
`timescale 1ns / 1ps

package dtp_pkg;

  // Longest token, sign included, that may carry a thousands separator.
  localparam int TOKEN_CAPACITY = 128;
  // Digit counter saturates at TOKEN_CAPACITY + 1.
  localparam int CNT_W = $clog2(TOKEN_CAPACITY + 2);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(TOKEN_CAPACITY + 1);
  localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(TOKEN_CAPACITY);

  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Configuration register indexes.
  localparam logic [0:0] CFG_SEPARATOR = 1'd0;
  localparam logic [0:0] CFG_UNSIGNED = 1'd1;

  // Result error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NO_DIGITS = 2'd1;
  localparam logic [1:0] ERR_INVALID = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef enum logic [5:0] {
    PH_LEAD  = 6'b000001,
    PH_SIGN  = 6'b000010,
    PH_NUM   = 6'b000100,
    PH_TAIL  = 6'b001000,
    PH_JUNK  = 6'b010000,
    PH_NODIG = 6'b100000
  } phase_t;

  // Per-field parse state; also the snapshot handed to the result stage.
  typedef struct packed {
    phase_t           phase;
    logic [63:0]      acc;
    logic             ovf;
    logic             neg;
    logic             sign_seen;
    logic [CNT_W-1:0] cnt;
    logic             sep_seen;
  } field_snap_t;

  localparam field_snap_t FIELD_CLEAR = '{
    phase:     PH_LEAD,
    acc:       64'd0,
    ovf:       1'b0,
    neg:       1'b0,
    sign_seen: 1'b0,
    cnt:       '0,
    sep_seen:  1'b0
  };

  function automatic logic is_white(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
  endfunction

endpackage

@@ src/dtp_field_fsm.sv @@
`timescale 1ns / 1ps

// Consumes one character per cycle while fire is high and tracks the
// running field state; snap is the state after the current character.
module dtp_field_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           char_byte,
  input  logic                 has_char,
  input  logic                 last,
  input  logic [7:0]           sep_char,
  output dtp_pkg::field_snap_t snap
);

  dtp_pkg::field_snap_t st_r;
  dtp_pkg::field_snap_t st_nxt;
  dtp_pkg::field_snap_t dig_st;
  logic                 is_digit;
  logic                 is_sep;
  logic                 is_ws;
  logic [67:0]          prod;

  always_comb begin
    is_digit = (char_byte >= dtp_pkg::CHAR_ZERO) && (char_byte <= dtp_pkg::CHAR_NINE);
    is_sep   = (sep_char != 8'd0) && (char_byte == sep_char);
    is_ws    = dtp_pkg::is_white(char_byte);

    // acc * 10 + digit as (acc << 3) + (acc << 1) + digit.
    prod = {1'b0, st_r.acc, 3'b000} + {3'b000, st_r.acc, 1'b0} + {64'd0, char_byte[3:0]};

    dig_st       = st_r;
    dig_st.acc   = prod[63:0];
    dig_st.ovf   = st_r.ovf | (|prod[67:64]);
    dig_st.phase = dtp_pkg::PH_NUM;
    if (st_r.cnt < dtp_pkg::CNT_SAT) begin
      dig_st.cnt = st_r.cnt + 1'b1;
    end

    st_nxt = st_r;
    if (has_char) begin
      case (st_r.phase)
        dtp_pkg::PH_LEAD: begin
          if (is_ws) begin
            st_nxt = st_r;
          end else if (char_byte == dtp_pkg::CHAR_PLUS || char_byte == dtp_pkg::CHAR_MINUS) begin
            st_nxt.sign_seen = 1'b1;
            st_nxt.neg       = (char_byte == dtp_pkg::CHAR_MINUS);
            st_nxt.phase     = dtp_pkg::PH_SIGN;
          end else if (is_digit) begin
            st_nxt = dig_st;
          end else begin
            st_nxt.phase = dtp_pkg::PH_NODIG;
          end
        end
        dtp_pkg::PH_SIGN: begin
          if (is_digit) begin
            st_nxt = dig_st;
          end else begin
            st_nxt.phase = dtp_pkg::PH_NODIG;
          end
        end
        dtp_pkg::PH_NUM: begin
          if (is_digit) begin
            st_nxt = dig_st;
          end else if (is_sep) begin
            st_nxt = st_r;
          end else if (is_ws) begin
            st_nxt.phase = dtp_pkg::PH_TAIL;
          end else begin
            st_nxt.phase = dtp_pkg::PH_JUNK;
          end
        end
        dtp_pkg::PH_TAIL: begin
          if (!is_ws) begin
            st_nxt.phase = dtp_pkg::PH_JUNK;
          end
        end
        default: begin
          st_nxt = st_r;
        end
      endcase
      // The separator counts anywhere in the field, whatever the phase.
      if (is_sep) begin
        st_nxt.sep_seen = 1'b1;
      end
    end
    snap = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dtp_pkg::FIELD_CLEAR;
    end else if (fire) begin
      st_r <= last ? dtp_pkg::FIELD_CLEAR : st_nxt;
    end
  end

endmodule

@@ src/dtp_result.sv @@
`timescale 1ns / 1ps

// Holds the end-of-field snapshot, makes the final decision and drives the
// output register together with the sticky flags.
module dtp_result (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 snap_load,
  input  dtp_pkg::field_snap_t snap,
  input  logic                 unsigned_mode,
  output logic                 snap_free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata
);

  logic                 snap_v_r;
  dtp_pkg::field_snap_t snap_r;
  logic                 out_v_r;
  logic [63:0]          value_r;
  logic [1:0]           err_r;
  logic                 neg_flag_r;
  logic                 large_flag_r;

  logic                 out_load;
  logic [63:0]          value_nxt;
  logic [1:0]           err_nxt;
  logic                 neg_flag_nxt;
  logic                 large_flag_nxt;
  logic                 has_digits;
  logic                 too_long;
  logic                 above_limit;
  logic [dtp_pkg::CNT_W:0] tok_len;

  assign out_load  = !out_v_r || out_tready;
  assign snap_free = !snap_v_r || out_load;

  always_comb begin
    has_digits = (snap_r.phase == dtp_pkg::PH_NUM) || (snap_r.phase == dtp_pkg::PH_TAIL) ||
                 (snap_r.phase == dtp_pkg::PH_JUNK);
    tok_len    = {1'b0, snap_r.cnt} + {{dtp_pkg::CNT_W{1'b0}}, snap_r.sign_seen};
    too_long   = has_digits && snap_r.sep_seen && (tok_len > dtp_pkg::CNT_LIMIT);
    // Signed limit is 2^63 - 1, or 2^63 for a negative value.
    if (unsigned_mode) begin
      above_limit = snap_r.ovf;
    end else begin
      above_limit = snap_r.ovf ||
                    (snap_r.acc[63] && (!snap_r.neg || (snap_r.acc[62:0] != 63'd0)));
    end

    value_nxt      = 64'd0;
    err_nxt        = dtp_pkg::ERR_NONE;
    neg_flag_nxt   = neg_flag_r;
    large_flag_nxt = large_flag_r;
    if (too_long) begin
      err_nxt = dtp_pkg::ERR_OVERFLOW;
    end else if (unsigned_mode && snap_r.neg) begin
      neg_flag_nxt = 1'b1;
    end else if (!has_digits) begin
      err_nxt = dtp_pkg::ERR_NO_DIGITS;
    end else if (above_limit) begin
      err_nxt = (snap_r.phase == dtp_pkg::PH_NUM) ? dtp_pkg::ERR_OVERFLOW : dtp_pkg::ERR_INVALID;
    end else if (snap_r.phase == dtp_pkg::PH_JUNK) begin
      err_nxt = dtp_pkg::ERR_INVALID;
    end else begin
      if (unsigned_mode && snap_r.acc[63]) begin
        large_flag_nxt = 1'b1;
      end
      value_nxt = snap_r.neg ? (64'd0 - snap_r.acc) : snap_r.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      neg_flag_r   <= 1'b0;
      large_flag_r <= 1'b0;
    end else begin
      if (snap_free) begin
        snap_v_r <= snap_load;
      end
      if (out_load) begin
        out_v_r <= snap_v_r;
      end
      if (out_load && snap_v_r) begin
        neg_flag_r   <= neg_flag_nxt;
        large_flag_r <= large_flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_free && snap_load) begin
      snap_r <= snap;
    end
    if (out_load && snap_v_r) begin
      value_r <= value_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, large_flag_r, neg_flag_r, err_r, value_r};

endmodule

@@ src/decimal_integer_text_parser.sv @@
`timescale 1ns / 1ps

// Streaming parser for one decimal integer field per frame of characters.
// Input channel: one character per transaction on in_tdata, in_tuser high
// when the byte is a real character, in_tlast high on the final transaction
// of the field (an empty field is a single transaction with in_tuser low).
// Output channel: one transaction per field carrying the 64-bit value, the
// error code and the two sticky flags, which only reset clears.
// Configuration: cfg_we writes register cfg_index (0 thousands separator,
// 1 unsigned mode) from cfg_wdata; write only while no field is in flight.
// Throughput is one character per cycle while in_tready is high, with
// back-to-back fields. The transaction carrying in_tlast passes through
// the input register and character logic into the snapshot register,
// then through the end-of-field decision into the output register.
// When the receiver stalls, the output register holds its result and the
// snapshot register takes the next finished field. Characters keep flowing
// until the final character of a further field reaches the input register;
// then in_tready drops until the receiver takes the waiting result.
// Reset clears the field state, the sticky flags and both config registers.
module decimal_integer_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel. in_tdata: [7:0] char_byte. in_tuser: [0] has_char.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  // Result channel. out_tdata: [63:0] value, [65:64] error_code,
  // [66] saw_negative_unsigned, [67] saw_above_signed_max, [71:68] zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]           sep_char_r;
  logic                 uns_r;
  logic                 in_v_r;
  logic [7:0]           char_r;
  logic                 has_char_r;
  logic                 last_r;
  logic                 char_fire;
  logic                 snap_free;
  dtp_pkg::field_snap_t snap;

  // Configuration registers; a separator of zero disables skipping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_char_r <= 8'd0;
      uns_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dtp_pkg::CFG_SEPARATOR: sep_char_r <= cfg_wdata;
        dtp_pkg::CFG_UNSIGNED:  uns_r      <= cfg_wdata[0];
        default:                uns_r      <= uns_r;
      endcase
    end
  end

  // A character moves on unless it ends a field and the snapshot is busy.
  assign char_fire = in_v_r && (!last_r || snap_free);
  assign in_tready = !in_v_r || char_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r     <= in_tdata;
      has_char_r <= in_tuser;
      last_r     <= in_tlast;
    end
  end

  dtp_field_fsm u_field (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (char_fire),
    .char_byte (char_r),
    .has_char  (has_char_r),
    .last      (last_r),
    .sep_char  (sep_char_r),
    .snap      (snap)
  );

  dtp_result u_result (
    .clk           (clk),
    .rst_n         (rst_n),
    .snap_load     (char_fire && last_r),
    .snap          (snap),
    .unsigned_mode (uns_r),
    .snap_free     (snap_free),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule
